>>> sv/spc_pkg.sv
// Shared types and constants for the sprite pixel compositor.
// Holds the configuration register indexes and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package spc_pkg;

    localparam int CLIP_POS_W  = 11;
    localparam int CLIP_LEN_W  = 12;
    localparam int COLOUR_W    = 16;
    localparam int ALPHA_W     = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLIP_LEFT    = 3'd0,
        CFG_CLIP_TOP     = 3'd1,
        CFG_CLIP_WIDTH   = 3'd2,
        CFG_CLIP_HEIGHT  = 3'd3,
        CFG_KEY_COLOUR   = 3'd4,
        CFG_KEY_ENABLE   = 3'd5,
        CFG_ALPHA_ENABLE = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [CLIP_POS_W-1:0] clip_left;
        logic [CLIP_POS_W-1:0] clip_top;
        logic [CLIP_LEN_W-1:0] clip_width;
        logic [CLIP_LEN_W-1:0] clip_height;
        logic [COLOUR_W-1:0]   key_colour;
        logic                  key_enable;
        logic                  alpha_enable;
    } t_cfg;

endpackage

>>> sv/sprite_pixel_compositor_top.sv
// Top level of the sprite pixel compositor: input register, drop and blend logic,
// result register. Depends on spc_pkg, spc_cfg, spc_drop and spc_blend.
`timescale 1ns / 1ps

// Usage:
// An item (pixel position, source colour, source alpha, framebuffer colour) is
// taken at each rising edge with i_start high and o_busy low. o_busy is always
// low, so one item can be taken every clock cycle.
// Each item gives exactly one result: o_valid is high for one cycle, after the
// input and result registers, with o_write_enable and o_result_colour. A dropped
// item (colour key hit or outside the clip rectangle) shows o_write_enable low
// and the framebuffer colour unchanged.
// Throughput is one item per cycle, with the input register and the result
// register around combinational drop and blend logic. The receiver cannot stall;
// results must be taken when o_valid is high. Registers are written through
// i_cfg_we, i_cfg_index and i_cfg_wdata only while no item is in flight; the user
// must keep to this, the block does not enforce it. A synchronous reset (i_rst_n
// low) zeroes the config and valid registers and discards any item in flight.
module sprite_pixel_compositor_top #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic signed [COORD_WIDTH-1:0]    i_pixel_x,
    input  logic signed [COORD_WIDTH-1:0]    i_pixel_y,
    input  logic [spc_pkg::COLOUR_W-1:0]     i_source_colour,
    input  logic [spc_pkg::ALPHA_W-1:0]      i_source_alpha,
    input  logic [spc_pkg::COLOUR_W-1:0]     i_dest_colour,
    input  logic                             i_cfg_we,
    input  logic [spc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output logic                             o_valid,
    output logic                             o_write_enable,
    output logic [spc_pkg::COLOUR_W-1:0]     o_result_colour
);
    import spc_pkg::*;

    t_cfg                           cfg;
    logic                           r_in_valid;
    logic signed [COORD_WIDTH-1:0]  r_pixel_x;
    logic signed [COORD_WIDTH-1:0]  r_pixel_y;
    logic [COLOUR_W-1:0]            r_source_colour;
    logic [ALPHA_W-1:0]             r_source_alpha;
    logic [COLOUR_W-1:0]            r_dest_colour;
    logic                           drop;
    logic [COLOUR_W-1:0]            blended;
    logic                           n_write_enable;
    logic [COLOUR_W-1:0]            n_result_colour;
    logic                           r_valid;
    logic                           r_write_enable;
    logic [COLOUR_W-1:0]            r_result_colour;
    logic                           accept;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    spc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel_x       <= i_pixel_x;
            r_pixel_y       <= i_pixel_y;
            r_source_colour <= i_source_colour;
            r_source_alpha  <= i_source_alpha;
            r_dest_colour   <= i_dest_colour;
        end
    end

    spc_drop #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_drop (
        .i_cfg           (cfg),
        .i_pixel_x       (r_pixel_x),
        .i_pixel_y       (r_pixel_y),
        .i_source_colour (r_source_colour),
        .o_drop          (drop)
    );

    spc_blend u_blend (
        .i_source_colour (r_source_colour),
        .i_dest_colour   (r_dest_colour),
        .i_source_alpha  (r_source_alpha),
        .o_colour        (blended)
    );

    always_comb begin
        n_write_enable = r_in_valid && !drop;
        if (drop) begin
            n_result_colour = r_dest_colour;
        end else if (cfg.alpha_enable) begin
            n_result_colour = blended;
        end else begin
            n_result_colour = r_source_colour;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_write_enable <= 1'b0;
        end else begin
            r_valid        <= r_in_valid;
            r_write_enable <= n_write_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result_colour <= n_result_colour;
    end

    assign o_valid         = r_valid;
    assign o_write_enable  = r_write_enable;
    assign o_result_colour = r_result_colour;

    a_item_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_in_valid ##1 o_valid)
        else $error("accepted item did not produce a result");

    a_drop_keeps_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && drop) |=>
            (o_valid && !o_write_enable && o_result_colour == $past(r_dest_colour)))
        else $error("dropped item did not return the framebuffer colour");

    a_opaque_is_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !drop && cfg.alpha_enable && r_source_alpha == 8'hFF) |=>
            (o_write_enable && o_result_colour == $past(r_source_colour)))
        else $error("opaque blend did not return the source colour");

    a_write_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_enable |-> o_valid)
        else $error("write enable without a result strobe");

endmodule

>>> sv/spc_cfg.sv
// Configuration register file of the sprite pixel compositor.
// Depends on spc_pkg for the register indexes and the t_cfg struct.
`timescale 1ns / 1ps

module spc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [spc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output spc_pkg::t_cfg                  o_cfg
);
    import spc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CLIP_LEFT:    n_cfg.clip_left    = i_cfg_wdata[CLIP_POS_W-1:0];
                CFG_CLIP_TOP:     n_cfg.clip_top     = i_cfg_wdata[CLIP_POS_W-1:0];
                CFG_CLIP_WIDTH:   n_cfg.clip_width   = i_cfg_wdata[CLIP_LEN_W-1:0];
                CFG_CLIP_HEIGHT:  n_cfg.clip_height  = i_cfg_wdata[CLIP_LEN_W-1:0];
                CFG_KEY_COLOUR:   n_cfg.key_colour   = i_cfg_wdata[COLOUR_W-1:0];
                CFG_KEY_ENABLE:   n_cfg.key_enable   = i_cfg_wdata[0];
                CFG_ALPHA_ENABLE: n_cfg.alpha_enable = i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/spc_drop.sv
// Drop decision: clip rectangle test and colour key test for one item.
// Depends on spc_pkg for t_cfg and the field widths.
`timescale 1ns / 1ps

module spc_drop #(
    parameter int COORD_WIDTH = 12
) (
    input  spc_pkg::t_cfg                   i_cfg,
    input  logic signed [COORD_WIDTH-1:0]   i_pixel_x,
    input  logic signed [COORD_WIDTH-1:0]   i_pixel_y,
    input  logic [spc_pkg::COLOUR_W-1:0]    i_source_colour,
    output logic                            o_drop
);
    import spc_pkg::*;

    localparam int MW = (COORD_WIDTH - 1 > CLIP_LEN_W + 1) ? COORD_WIDTH - 1 : CLIP_LEN_W + 1;

    logic [MW-1:0] x_mag;
    logic [MW-1:0] y_mag;
    logic [MW-1:0] x_lo;
    logic [MW-1:0] y_lo;
    logic [MW-1:0] x_hi;
    logic [MW-1:0] y_hi;
    logic          x_in;
    logic          y_in;
    logic          keyed;

    assign x_mag = MW'(i_pixel_x[COORD_WIDTH-2:0]);
    assign y_mag = MW'(i_pixel_y[COORD_WIDTH-2:0]);
    assign x_lo  = MW'(i_cfg.clip_left);
    assign y_lo  = MW'(i_cfg.clip_top);
    assign x_hi  = MW'(i_cfg.clip_left) + MW'(i_cfg.clip_width);
    assign y_hi  = MW'(i_cfg.clip_top) + MW'(i_cfg.clip_height);

    // A negative coordinate is never inside the rectangle.
    assign x_in  = !i_pixel_x[COORD_WIDTH-1] && (x_mag >= x_lo) && (x_mag < x_hi);
    assign y_in  = !i_pixel_y[COORD_WIDTH-1] && (y_mag >= y_lo) && (y_mag < y_hi);
    assign keyed = i_cfg.key_enable && (i_source_colour == i_cfg.key_colour);

    assign o_drop = keyed || !x_in || !y_in;

endmodule

>>> sv/spc_blend.sv
// Per-channel alpha blend of two byte-swapped RGB565 colours.
// Depends on spc_pkg for the colour and alpha widths.
`timescale 1ns / 1ps

module spc_blend (
    input  logic [spc_pkg::COLOUR_W-1:0] i_source_colour,
    input  logic [spc_pkg::COLOUR_W-1:0] i_dest_colour,
    input  logic [spc_pkg::ALPHA_W-1:0]  i_source_alpha,
    output logic [spc_pkg::COLOUR_W-1:0] o_colour
);
    import spc_pkg::*;

    logic [COLOUR_W-1:0] us;
    logic [COLOUR_W-1:0] ud;
    logic [ALPHA_W:0]    inv_a;
    logic [14:0]         sum_r;
    logic [14:0]         sum_g;
    logic [14:0]         sum_b;
    logic [COLOUR_W-1:0] raw;

    assign us    = {i_source_colour[7:0], i_source_colour[15:8]};
    assign ud    = {i_dest_colour[7:0], i_dest_colour[15:8]};
    assign inv_a = 9'd256 - {1'b0, i_source_alpha};

    assign sum_r = 15'(us[15:11]) * 15'(i_source_alpha) + 15'(ud[15:11]) * 15'(inv_a);
    assign sum_g = 15'(us[10:5])  * 15'(i_source_alpha) + 15'(ud[10:5])  * 15'(inv_a);
    assign sum_b = 15'(us[4:0])   * 15'(i_source_alpha) + 15'(ud[4:0])   * 15'(inv_a);

    assign raw = {sum_r[12:8], sum_g[13:8], sum_b[12:8]};

    always_comb begin
        if (i_source_alpha == 8'h00) begin
            o_colour = i_dest_colour;
        end else if (i_source_alpha == 8'hFF) begin
            o_colour = i_source_colour;
        end else begin
            o_colour = {raw[7:0], raw[15:8]};
        end
    end

endmodule
